/* rtl/core/gg_pkg.sv */
`default_nettype none
package gg_pkg;

   localparam int MAX_FEATURES = 4096;
   localparam int DATA_WIDTH   = 16;
   localparam int COL_WIDTH    = $clog2(MAX_FEATURES);
   localparam int FC_WIDTH     = 13;
   localparam int PROD_WIDTH   = 54;
   localparam int MUL_A_WIDTH  = 36;
   localparam int MUL_B_WIDTH  = 18;
   localparam int BETA_Q16     = 2930;
   localparam int ALPHA_Q16    = 52290;
   localparam int TANH_POINTS  = 257;
   localparam int TANH_SAT     = 16384;
   localparam int ONE_Q15      = 32768;

   typedef logic [15:0] tanh_tab_type [0:TANH_POINTS-1];

   // Multiplier pass selected by the controller
   typedef enum logic [3:0] {
      OP_NONE, OP_XX, OP_X2X, OP_BETA, OP_ALPHA, OP_TANH, OP_G, OP_GZ, OP_S, OP_Y
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_XX, ST_X2X, ST_BETA, ST_ALPHA, ST_TANH, ST_G, ST_GZ, ST_S, ST_Y
   } state_type;

   typedef struct packed {
      logic   start;
      logic   load;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   // Build tanh(k/64) in Q.15 from a repeated e^(1/32) step
   function automatic tanh_tab_type build_tanh();
      tanh_tab_type tab;
      logic [63:0]  one;
      logic [63:0]  e;
      logic [63:0]  den;
      logic [63:0]  num;
      logic [63:0]  rem;
      logic [63:0]  quo;
      one    = 64'd1 << 20;
      e      = one;
      tab[0] = 16'd0;
      for (int k = 1; k < TANH_POINTS; k++) begin
         e   = (e * 64'd1107826048 + (64'd1 << 29)) >> 30;
         den = e + one;
         num = ((e - one) << 15) + (den >> 1);
         rem = 64'd0;
         quo = 64'd0;
         for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
               rem    = rem - den;
               quo[b] = 1'b1;
            end
         end
         tab[k] = quo[15:0];
      end
      return tab;
   endfunction

   localparam tanh_tab_type TANH_TAB = build_tanh();

   // Shift right, rounding half away from zero
   function automatic logic signed [PROD_WIDTH-1:0] rnd(
      input logic signed [PROD_WIDTH-1:0] v, input int unsigned s);
      logic [PROD_WIDTH-1:0] mag;
      mag = v[PROD_WIDTH-1] ? PROD_WIDTH'(-v) : PROD_WIDTH'(v);
      mag = (mag + (PROD_WIDTH'(1) << (s - 1))) >> s;
      return v[PROD_WIDTH-1] ? -$signed(mag) : $signed(mag);
   endfunction

   // Clamp to the signed data range
   function automatic logic signed [DATA_WIDTH-1:0] sat(
      input logic signed [PROD_WIDTH-1:0] v);
      logic signed [PROD_WIDTH-1:0] hi;
      logic signed [PROD_WIDTH-1:0] lo;
      hi = (PROD_WIDTH'(1) <<< (DATA_WIDTH - 1)) - 1;
      lo = -(PROD_WIDTH'(1) <<< (DATA_WIDTH - 1));
      if (v > hi) return DATA_WIDTH'(hi);
      if (v < lo) return DATA_WIDTH'(lo);
      return DATA_WIDTH'(v);
   endfunction

endpackage
`default_nettype wire

/* rtl/core/gg_if.sv */
`default_nettype none
interface gg_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [gg_pkg::COL_WIDTH-1:0]         scale_index;
   logic signed [gg_pkg::DATA_WIDTH-1:0] scale_value;
   logic signed [gg_pkg::DATA_WIDTH-1:0] x_value;
   logic signed [gg_pkg::DATA_WIDTH-1:0] z_value;

   modport source (output valid, mode, scale_index, scale_value, x_value, z_value,
                   input ready);
   modport sink (input valid, mode, scale_index, scale_value, x_value, z_value,
                 output ready);
endinterface

interface gg_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [gg_pkg::DATA_WIDTH-1:0] y_value;
   logic        row_last;

   modport source (output valid, y_value, row_last, input ready);
   modport sink (input valid, y_value, row_last, output ready);
endinterface
`default_nettype wire

/* rtl/core/gated_gelu_tanh_scaled.sv */
`default_nettype none
// Element request: the result is registered by the final pass, after eight passes
// through the single shared 36x18 multiplier; no new request is taken meanwhile.
// Load request: one per cycle while idle, stored in the scale memory with no result.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active high): sequencer idle, column 0, feature_count 1,
// output empty; the scale memory is not cleared.
module gated_gelu_tanh_scaled (
   input  wire logic        clock,
   input  wire logic        reset,
   gg_req_if.sink           req_chan,
   gg_rsp_if.source         rsp_chan,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [gg_pkg::FC_WIDTH-1:0] fc_ff;
   gg_pkg::cmd_type             cmd;
   gg_pkg::status_type          status;
   logic                        req_ready;

   // Register file: feature_count at address 0
   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff <= gg_pkg::FC_WIDTH'(1);
      end else if (psel && penable && pwrite && !paddr[2]) begin
         fc_ff <= pwdata[gg_pkg::FC_WIDTH-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : 32'(fc_ff);

   gg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gg_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .feature_count   (fc_ff),
      .req_scale_index (req_chan.scale_index),
      .req_scale_value (req_chan.scale_value),
      .req_x_value     (req_chan.x_value),
      .req_z_value     (req_chan.z_value),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_y_value     (rsp_chan.y_value),
      .rsp_row_last    (rsp_chan.row_last)
   );

   assign req_chan.ready = req_ready;

   // An element request blocks the next request while it is in flight
   a_elem_busy: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_ready && req_chan.mode |=> !req_chan.ready)
      else $error("request taken while an element is in flight");

   // A result appears only from the final pass
   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.op == gg_pkg::OP_Y))
      else $error("result raised without a final pass");

   // Reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid after reset");

endmodule
`default_nettype wire

/* rtl/core/gg_ctrl.sv */
`default_nettype none
module gg_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_mode,
   output logic                   req_ready,
   input  wire gg_pkg::status_type status,
   output gg_pkg::cmd_type        cmd
);

   gg_pkg::state_type state_ff;
   gg_pkg::state_type state_in;

   // Hold the sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Step through the multiplier passes
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '{start: 1'b0, load: 1'b0, op: gg_pkg::OP_NONE};
      case (state_ff)
         gg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_mode) begin
               cmd.start = 1'b1;
               state_in  = gg_pkg::ST_XX;
            end else if (req_valid) begin
               cmd.load = 1'b1;
            end
         end
         gg_pkg::ST_XX: begin
            cmd.op   = gg_pkg::OP_XX;
            state_in = gg_pkg::ST_X2X;
         end
         gg_pkg::ST_X2X: begin
            cmd.op   = gg_pkg::OP_X2X;
            state_in = gg_pkg::ST_BETA;
         end
         gg_pkg::ST_BETA: begin
            cmd.op   = gg_pkg::OP_BETA;
            state_in = gg_pkg::ST_ALPHA;
         end
         gg_pkg::ST_ALPHA: begin
            cmd.op   = gg_pkg::OP_ALPHA;
            state_in = gg_pkg::ST_TANH;
         end
         gg_pkg::ST_TANH: begin
            cmd.op   = gg_pkg::OP_TANH;
            state_in = gg_pkg::ST_G;
         end
         gg_pkg::ST_G: begin
            cmd.op   = gg_pkg::OP_G;
            state_in = gg_pkg::ST_GZ;
         end
         gg_pkg::ST_GZ: begin
            cmd.op   = gg_pkg::OP_GZ;
            state_in = gg_pkg::ST_S;
         end
         gg_pkg::ST_S: begin
            cmd.op   = gg_pkg::OP_S;
            state_in = gg_pkg::ST_Y;
         end
         gg_pkg::ST_Y: begin
            // wait for the output register to drain
            if (status.out_free) begin
               cmd.op   = gg_pkg::OP_Y;
               state_in = gg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gg_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

/* rtl/core/gg_dp.sv */
`default_nettype none
module gg_dp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire gg_pkg::cmd_type                       cmd,
   output gg_pkg::status_type                         status,
   input  wire logic [gg_pkg::FC_WIDTH-1:0]           feature_count,
   input  wire logic [gg_pkg::COL_WIDTH-1:0]          req_scale_index,
   input  wire logic signed [gg_pkg::DATA_WIDTH-1:0]  req_scale_value,
   input  wire logic signed [gg_pkg::DATA_WIDTH-1:0]  req_x_value,
   input  wire logic signed [gg_pkg::DATA_WIDTH-1:0]  req_z_value,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [gg_pkg::DATA_WIDTH-1:0]       rsp_y_value,
   output logic                                       rsp_row_last
);

   localparam int PW = gg_pkg::PROD_WIDTH;
   localparam int DW = gg_pkg::DATA_WIDTH;
   localparam int CW = gg_pkg::COL_WIDTH;
   localparam int FW = gg_pkg::FC_WIDTH;

   logic signed [DW-1:0] scale_mem [0:gg_pkg::MAX_FEATURES-1];

   logic [CW-1:0]        col_ff;
   logic [CW-1:0]        col_in;
   logic                 last_pend_ff;
   logic signed [DW-1:0] x_ff;
   logic signed [DW-1:0] z_ff;
   logic signed [DW-1:0] scale_rd_ff;
   logic signed [PW-1:0] prod_ff;
   logic [15:0]          lo_ff;
   logic                 big_ff;
   logic                 neg_ff;
   logic                 valid_ff;
   logic signed [DW-1:0] y_ff;
   logic                 last_ff;

   logic [FW-1:0]        fc_eff;
   logic                 last;
   logic signed [gg_pkg::MUL_A_WIDTH-1:0] mul_a;
   logic signed [gg_pkg::MUL_B_WIDTH-1:0] mul_b;
   logic signed [PW-1:0] mul_p;
   logic signed [PW-1:0] r6;
   logic signed [PW-1:0] r12;
   logic signed [PW-1:0] r16;
   logic signed [PW-1:0] r28;
   logic [PW-1:0]        a_mag;
   logic                 x_big;
   logic                 u_big;
   logic [7:0]           tab_i;
   logic [8:0]           tab_i1;
   logic [5:0]           frac;
   logic [15:0]          tab_lo;
   logic [15:0]          tab_hi;
   logic [17:0]          tv;
   logic signed [17:0]   tsgn;
   logic signed [DW-1:0] gz;

   // Row length: zero counts as one, clamp to the table depth
   always_comb begin
      if (feature_count == '0) begin
         fc_eff = FW'(1);
      end else if (feature_count > FW'(gg_pkg::MAX_FEATURES)) begin
         fc_eff = FW'(gg_pkg::MAX_FEATURES);
      end else begin
         fc_eff = feature_count;
      end
      last   = ({1'b0, col_ff} + FW'(1)) >= fc_eff;
      col_in = last ? '0 : col_ff + CW'(1);
   end

   // Advance the column on each element
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (cmd.start) begin
         col_ff <= col_in;
      end
   end

   // Scale table: write on loads, read the current column on elements
   always_ff @(posedge clock) begin
      if (cmd.load && ({1'b0, req_scale_index} < (CW+1)'(gg_pkg::MAX_FEATURES))) begin
         scale_mem[req_scale_index] <= req_scale_value;
      end
      if (cmd.start) begin
         scale_rd_ff <= scale_mem[col_ff];
      end
   end

   // Rounded views of the last product, tanh table lookup and saturated result
   always_comb begin
      r6     = gg_pkg::rnd(prod_ff, 6);
      r12    = gg_pkg::rnd(prod_ff, 12);
      r16    = gg_pkg::rnd(prod_ff, 16);
      r28    = gg_pkg::rnd(prod_ff, 28);
      x_big  = (x_ff == {1'b1, {(DW-1){1'b0}}});
      a_mag  = r16[PW-1] ? PW'(-r16) : PW'(r16);
      u_big  = x_big || (a_mag >= PW'(gg_pkg::TANH_SAT));
      tab_i  = a_mag[13:6];
      tab_i1 = {1'b0, tab_i} + 9'd1;
      frac   = a_mag[5:0];
      tab_lo = gg_pkg::TANH_TAB[tab_i];
      tab_hi = gg_pkg::TANH_TAB[tab_i1];
      tv     = big_ff ? 18'(gg_pkg::ONE_Q15) : 18'(lo_ff) + 18'(r6);
      tsgn   = neg_ff ? -$signed(tv) : $signed(tv);
      gz     = gg_pkg::sat(r12);
   end

   // Select operands for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         gg_pkg::OP_XX: begin
            mul_a = 36'(x_ff);
            mul_b = 18'(x_ff);
         end
         gg_pkg::OP_X2X: begin
            mul_a = 36'(r12);
            mul_b = 18'(x_ff);
         end
         gg_pkg::OP_BETA: begin
            mul_a = 36'(prod_ff);
            mul_b = 18'(gg_pkg::BETA_Q16);
         end
         gg_pkg::OP_ALPHA: begin
            mul_a = 36'(x_ff) + 36'(r28);
            mul_b = 18'(gg_pkg::ALPHA_Q16);
         end
         gg_pkg::OP_TANH: begin
            mul_a = 36'($signed({1'b0, tab_hi})) - 36'($signed({1'b0, tab_lo}));
            mul_b = {12'd0, frac};
         end
         gg_pkg::OP_G: begin
            mul_a = 36'(x_ff);
            mul_b = 18'(gg_pkg::ONE_Q15) + tsgn;
         end
         gg_pkg::OP_GZ: begin
            mul_a = 36'(r16);
            mul_b = 18'(z_ff);
         end
         gg_pkg::OP_S: begin
            mul_a = 36'(gz);
            mul_b = 18'(scale_rd_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = PW'(mul_a) * PW'(mul_b);

   // Capture operands, products and the tanh segment
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x_ff         <= req_x_value;
         z_ff         <= req_z_value;
         last_pend_ff <= last;
      end
      if (cmd.op != gg_pkg::OP_NONE && cmd.op != gg_pkg::OP_Y) begin
         prod_ff <= mul_p;
      end
      if (cmd.op == gg_pkg::OP_TANH) begin
         lo_ff  <= tab_lo;
         big_ff <= u_big;
         neg_ff <= x_big ? 1'b1 : r16[PW-1];
      end
   end

   // Output register: load the result, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.op == gg_pkg::OP_Y) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
      if (cmd.op == gg_pkg::OP_Y) begin
         y_ff    <= gz;
         last_ff <= last_pend_ff;
      end
   end

   assign status.out_free = !valid_ff || rsp_ready;
   assign rsp_valid       = valid_ff;
   assign rsp_y_value     = y_ff;
   assign rsp_row_last    = last_ff;

endmodule
`default_nettype wire
